// ===== rtl/core/pfrgb_pkg.sv =====
// pfrgb_pkg: shared types, format codes and constants of the pixel format converter
// no dependencies; used by every module under rtl/core except pfrgb_checker
package pfrgb_pkg;

    // source format codes
    localparam logic [3:0] FMT_GRAY     = 4'd0;
    localparam logic [3:0] FMT_RGB      = 4'd1;
    localparam logic [3:0] FMT_BGR      = 4'd2;
    localparam logic [3:0] FMT_RGBA     = 4'd3;
    localparam logic [3:0] FMT_BGRA     = 4'd4;
    localparam logic [3:0] FMT_ARGB     = 4'd5;
    localparam logic [3:0] FMT_ABGR     = 4'd6;
    localparam logic [3:0] FMT_CBYCRY   = 4'd7;
    localparam logic [3:0] FMT_YCBYCR   = 4'd8;
    localparam logic [3:0] FMT_RGB565   = 4'd9;
    localparam logic [3:0] FMT_RGBA5551 = 4'd10;
    localparam logic [3:0] FMT_RGBA4444 = 4'd11;

    // register addresses
    localparam logic [1:0] ADDR_SOURCE_FORMAT = 2'd0;

    // bt.601 coefficients, q18 scaling (18 fraction bits)
    localparam logic signed [20:0] K_Y  = 21'sd305236;
    localparam logic signed [20:0] K_RV = 21'sd418389;
    localparam logic signed [20:0] K_GU = 21'sd102698;
    localparam logic signed [20:0] K_GV = 21'sd213115;
    localparam logic signed [20:0] K_BU = 21'sd528805;

    localparam int PROD_W = 30;

    // queue entry: direct pixels use b0..b2 as r,g,b;
    // 4:2:2 words use b0=y0, b1=y1, b2=cb, b3=cr
    typedef struct packed {
        logic       is_ycc;
        logic       gray;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } qent_t;

    // handshake between queue and back end
    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qhead_t;

    // negative sums give 0; otherwise drop 18 fraction bits and saturate
    function automatic logic [7:0] clamp8(input logic signed [PROD_W-1:0] s);
        logic [7:0] r;
        if (s[PROD_W-1])
            r = 8'd0;
        else if (|s[PROD_W-2:26])
            r = 8'hff;
        else
            r = s[25:18];
        return r;
    endfunction

endpackage

// ===== rtl/core/pfrgb_front.sv =====
// pfrgb_front: decodes an input word under the source format into a queue entry
// depends on pfrgb_pkg
module pfrgb_front
(
    input  logic [3:0]      source_format,
    input  logic [7:0]      byte_a,
    input  logic [7:0]      byte_b,
    input  logic [7:0]      byte_c,
    input  logic [7:0]      byte_d,
    output pfrgb_pkg::qent_t ent
);

    always_comb
    begin
        ent = '0;
        case (source_format)
            pfrgb_pkg::FMT_GRAY:
            begin
                ent.gray = 1'b1;
                ent.b0   = byte_a;
            end
            pfrgb_pkg::FMT_RGB, pfrgb_pkg::FMT_RGBA:
            begin
                ent.b0 = byte_a;
                ent.b1 = byte_b;
                ent.b2 = byte_c;
            end
            pfrgb_pkg::FMT_BGR, pfrgb_pkg::FMT_BGRA:
            begin
                ent.b0 = byte_c;
                ent.b1 = byte_b;
                ent.b2 = byte_a;
            end
            pfrgb_pkg::FMT_ARGB:
            begin
                ent.b0 = byte_b;
                ent.b1 = byte_c;
                ent.b2 = byte_d;
            end
            pfrgb_pkg::FMT_ABGR:
            begin
                ent.b0 = byte_d;
                ent.b1 = byte_c;
                ent.b2 = byte_b;
            end
            pfrgb_pkg::FMT_CBYCRY:
            begin
                ent.is_ycc = 1'b1;
                ent.b0     = byte_b;
                ent.b1     = byte_d;
                ent.b2     = byte_a;
                ent.b3     = byte_c;
            end
            pfrgb_pkg::FMT_YCBYCR:
            begin
                ent.is_ycc = 1'b1;
                ent.b0     = byte_a;
                ent.b1     = byte_c;
                ent.b2     = byte_b;
                ent.b3     = byte_d;
            end
            pfrgb_pkg::FMT_RGB565:
            begin
                ent.b0 = {byte_a[7:3], 3'b100};
                ent.b1 = {byte_a[2:0], byte_b[7:5], 2'b10};
                ent.b2 = {byte_b[4:0], 3'b100};
            end
            pfrgb_pkg::FMT_RGBA5551:
            begin
                // green takes three bits of byte_a and two of byte_b, then the offset
                ent.b0 = {byte_a[7:3], 3'b100};
                ent.b1 = {byte_a[2:0], byte_b[7:6], 3'b100};
                ent.b2 = {byte_b[5:1], 3'b100};
            end
            pfrgb_pkg::FMT_RGBA4444:
            begin
                ent.b0 = {byte_a[7:4], 4'b1000};
                ent.b1 = {byte_a[3:0], 4'b1000};
                ent.b2 = {byte_b[7:4], 4'b1000};
            end
            default:
            begin
                ent = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/pfrgb_queue.sv =====
// pfrgb_queue: two-entry queue between the decode front and the conversion back end
// depends on pfrgb_pkg
module pfrgb_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pfrgb_pkg::qent_t push_ent,
    output logic             full,
    input  logic             pop,
    output pfrgb_pkg::qhead_t head
);

    pfrgb_pkg::qent_t slot_reg [2];
    pfrgb_pkg::qent_t slot_next [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (push)
            slot_next[wr_ptr_reg] = push_ent;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = count_reg[1];
    assign head.valid = (count_reg != 2'd0);
    assign head.ent   = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/pfrgb_back.sv =====
// pfrgb_back: issues results from queue entries, multiplies, sums and clamps 4:2:2 pixels
// depends on pfrgb_pkg
module pfrgb_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  pfrgb_pkg::qhead_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic [0:0]        m_tuser,
    output logic              m_tlast
);

    localparam int PW = pfrgb_pkg::PROD_W;

    // issue side
    logic phase_reg, phase_next;
    logic issue, rdy1, rdy2;

    // product stage
    logic                 v1_reg, v1_next;
    logic                 ycc1_reg, gray1_reg, last1_reg;
    logic [23:0]          rgb1_reg;
    logic signed [PW-1:0] py_reg, prv_reg, pgu_reg, pgv_reg, pbu_reg;

    // output stage
    logic        v2_reg, v2_next;
    logic [23:0] data2_reg, data2_next;
    logic        gray2_reg, gray2_next;
    logic        last2_reg, last2_next;

    logic [7:0]          ysel;
    logic signed [8:0]   ys, us, vs;
    logic signed [PW-1:0] sum_r, sum_g, sum_b;

    assign rdy2  = !v2_reg || m_tready;
    assign rdy1  = !v1_reg || rdy2;
    assign issue = head.valid && rdy1;
    // a 4:2:2 entry stays at the head for its first result
    assign pop   = issue && (!head.ent.is_ycc || phase_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (issue && head.ent.is_ycc)
            phase_next = ~phase_reg;
        v1_next = rdy1 ? issue : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
    end

    assign ysel = phase_reg ? head.ent.b1 : head.ent.b0;
    assign ys   = $signed({1'b0, ysel}) - 9'sd16;
    assign us   = $signed({1'b0, head.ent.b2}) - 9'sd128;
    assign vs   = $signed({1'b0, head.ent.b3}) - 9'sd128;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ycc1_reg  <= head.ent.is_ycc;
            gray1_reg <= head.ent.gray;
            last1_reg <= !head.ent.is_ycc || phase_reg;
            rgb1_reg  <= {head.ent.b2, head.ent.b1, head.ent.b0};
            py_reg    <= PW'(pfrgb_pkg::K_Y)  * PW'(ys);
            prv_reg   <= PW'(pfrgb_pkg::K_RV) * PW'(vs);
            pgu_reg   <= PW'(pfrgb_pkg::K_GU) * PW'(us);
            pgv_reg   <= PW'(pfrgb_pkg::K_GV) * PW'(vs);
            pbu_reg   <= PW'(pfrgb_pkg::K_BU) * PW'(us);
        end
    end

    assign sum_r = py_reg + prv_reg;
    assign sum_g = py_reg - pgu_reg - pgv_reg;
    assign sum_b = py_reg + pbu_reg;

    always_comb
    begin
        data2_next = data2_reg;
        gray2_next = gray2_reg;
        last2_next = last2_reg;
        if (rdy2)
        begin
            if (ycc1_reg)
                data2_next = {pfrgb_pkg::clamp8(sum_b), pfrgb_pkg::clamp8(sum_g),
                              pfrgb_pkg::clamp8(sum_r)};
            else
                data2_next = rgb1_reg;
            gray2_next = gray1_reg;
            last2_next = last1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data2_reg <= data2_next;
        gray2_reg <= gray2_next;
        last2_reg <= last2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = data2_reg;
    assign m_tuser  = gray2_reg;
    assign m_tlast  = last2_reg;

endmodule

// ===== rtl/core/pixel_format_to_rgb888_top.sv =====
// pixel_format_to_rgb888_top: packed pixel to rgb888 converter with apb format register
// depends on pfrgb_pkg, pfrgb_front, pfrgb_queue, pfrgb_back
//
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    packed pixel bytes a..d
// m_*       out        m_tvalid / m_tready    red, green, blue, gray flag, last
// apb       in         psel/penable/pready    source_format at address 0
//
// one word accepted per cycle while the queue is not full; 4:2:2 words give two results,
// so they hold the back end for both, since it issues one result per cycle unless the output stalls
// a first result passes through the queue, the product registers and the output register
// no clearing pass after reset; source_format resets to gray
// a two-entry queue decouples input and output; input stalls only when it is full
module pixel_format_to_rgb888_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte_a, byte_b, byte_c, byte_d
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red, green, blue
    output logic [0:0]  m_tuser,   // gray_only
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] fmt_reg, fmt_next;
    logic       q_full, q_push, q_pop;
    pfrgb_pkg::qent_t  dec_ent;
    pfrgb_pkg::qhead_t q_head;

    assign pready = 1'b1;
    assign prdata = (paddr == pfrgb_pkg::ADDR_SOURCE_FORMAT) ? {28'd0, fmt_reg} : 32'd0;

    always_comb
    begin
        fmt_next = fmt_reg;
        if (psel && penable && pwrite && pready && paddr == pfrgb_pkg::ADDR_SOURCE_FORMAT)
            fmt_next = pwdata[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= pfrgb_pkg::FMT_GRAY;
        else
            fmt_reg <= fmt_next;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    pfrgb_front u_front
    (
        .source_format (fmt_reg),
        .byte_a        (s_tdata[7:0]),
        .byte_b        (s_tdata[15:8]),
        .byte_c        (s_tdata[23:16]),
        .byte_d        (s_tdata[31:24]),
        .ent           (dec_ent)
    );

    pfrgb_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (dec_ent),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    pfrgb_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/pfrgb_checker.sv =====
// pfrgb_checker: port-level assertions for the pixel format converter, bound to the top
// depends on pixel_format_to_rgb888_top ports only
module pfrgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast,
    input logic        pready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // gray words are single results with empty green and blue
    a_gray_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[23:8] == 16'd0)
        else $error("gray word malformed");

    // the second 4:2:2 result follows the first without a gap
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && !m_tuser[0])
        else $error("second 4:2:2 result missing");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind pixel_format_to_rgb888_top pfrgb_checker u_pfrgb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
